>>> rtl/core/lpg_pkg.sv
// Shared constants and controller/datapath interface types for the permutation generator.
package lpg_pkg;

  localparam int VAL_W       = 4;
  localparam int LEN_W       = 4;
  localparam int WORD_SLOTS  = 10;
  localparam int PW          = 40;
  localparam int CNT_W       = 22;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;
  localparam logic [LEN_W-1:0] LEN_RESET = 4'd10;

  typedef struct packed {
    logic fill_init;
    logic fill_wr;
    logic emit;
    logic piv;
    logic findj;
    logic sw1;
    logic sw2;
    logic rw1;
    logic rw2;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic out_full;
    logic any;
    logic done;
    logic sw_more;
    logic rw_more;
  } sts_t;

endpackage

>>> rtl/core/lpg_ram.sv
// Generic RAM: one write port, two registered read ports.
module lpg_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/core/lpg_datapath.sv
// Datapath: permutation store, shadow word, pivot/successor search, counter and output register.
module lpg_datapath #(
  parameter int MAX_LEN = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lpg_pkg::LEN_W-1:0]          cfg_wdata,
  input  lpg_pkg::cmd_t                      cmd,
  output lpg_pkg::sts_t                      sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lpg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser
);

  localparam int IW    = $clog2(MAX_LEN);
  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int SLOTS = (MAX_LEN < lpg_pkg::WORD_SLOTS) ? MAX_LEN : lpg_pkg::WORD_SLOTS;
  localparam int PAD_W = lpg_pkg::OUT_TDATA_W - lpg_pkg::CNT_W - lpg_pkg::PW;
  localparam logic [IW-1:0] LAST_POS = IW'(MAX_LEN - 1);

  logic [lpg_pkg::LEN_W-1:0]                   len_r;
  logic [LW-1:0]                               eff_len;
  logic [MAX_LEN-1:0][lpg_pkg::VAL_W-1:0]      sh_r, sh_nxt, ident;
  logic [IW-1:0]                               fc_r, i_r, j_r, lo_r, hi_r;
  logic [IW-1:0]                               piv_idx, j_idx;
  logic [lpg_pkg::VAL_W-1:0]                   piv_r, tmp_r, fill_val;
  logic [lpg_pkg::CNT_W-1:0]                   cnt_r;
  logic                                        done_r, any;
  logic [lpg_pkg::PW-1:0]                      word;
  logic                                        out_valid_r, out_last_r, out_user_r;
  logic [lpg_pkg::OUT_TDATA_W-1:0]             out_data_r;

  logic                                        we;
  logic [IW-1:0]                               waddr, raddr_a, raddr_b;
  logic [lpg_pkg::VAL_W-1:0]                   wdata, rdata_a, rdata_b;

  lpg_ram #(
    .WIDTH (lpg_pkg::VAL_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_comb begin
    if (len_r == '0) begin
      eff_len = LW'(1);
    end else if (int'(len_r) > MAX_LEN) begin
      eff_len = LW'(MAX_LEN);
    end else begin
      eff_len = LW'(len_r);
    end
  end

  // rightmost ascent and rightmost suffix value above the pivot
  always_comb begin
    any     = 1'b0;
    piv_idx = '0;
    for (int k = 0; k < MAX_LEN - 1; k++) begin
      if ((k + 2 <= int'(eff_len)) && (sh_r[k] < sh_r[k+1])) begin
        any     = 1'b1;
        piv_idx = IW'(k);
      end
    end
    j_idx = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      if ((k > int'(i_r)) && (k < int'(eff_len)) && (sh_r[k] > rdata_a)) begin
        j_idx = IW'(k);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_LEN; k++) begin
      ident[k] = (k < int'(eff_len)) ? lpg_pkg::VAL_W'(k + 1) : '0;
    end
    fill_val = (int'(fc_r) < int'(eff_len)) ? lpg_pkg::VAL_W'(int'(fc_r) + 1) : '0;
    word = '0;
    for (int k = 0; k < SLOTS; k++) begin
      word[4*k +: 4] = sh_r[k];
    end
  end

  always_comb begin
    we      = 1'b0;
    waddr   = fc_r;
    wdata   = fill_val;
    raddr_a = lo_r;
    raddr_b = hi_r;
    priority if (cmd.fill_wr) begin
      we = 1'b1;
    end else if (cmd.piv) begin
      raddr_a = i_r;
    end else if (cmd.findj) begin
      raddr_b = j_idx;
    end else if (cmd.sw1) begin
      we    = 1'b1;
      waddr = i_r;
      wdata = rdata_b;
    end else if (cmd.sw2) begin
      we    = 1'b1;
      waddr = j_r;
      wdata = piv_r;
    end else if (cmd.rw1) begin
      we    = 1'b1;
      waddr = lo_r;
      wdata = rdata_b;
    end else if (cmd.rw2) begin
      we      = 1'b1;
      waddr   = hi_r;
      wdata   = tmp_r;
      raddr_a = lo_r + 1'b1;
      raddr_b = hi_r - 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  always_comb begin
    sh_nxt = sh_r;
    if (cmd.fill_init) begin
      sh_nxt = ident;
    end else if (we) begin
      sh_nxt[waddr] = wdata;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    if (cmd.fill_init) begin
      fc_r <= '0;
    end else if (cmd.fill_wr) begin
      fc_r <= fc_r + 1'b1;
    end
    if (cmd.emit) begin
      i_r <= piv_idx;
    end
    if (cmd.findj) begin
      piv_r <= rdata_a;
      j_r   <= j_idx;
    end
    if (cmd.sw2) begin
      lo_r <= i_r + 1'b1;
      hi_r <= IW'(int'(eff_len) - 1);
    end else if (cmd.rw2) begin
      lo_r <= lo_r + 1'b1;
      hi_r <= hi_r - 1'b1;
    end
    if (cmd.rw1) begin
      tmp_r <= rdata_a;
    end
    if (cmd.emit) begin
      if (done_r) begin
        out_data_r <= '0;
        out_last_r <= 1'b0;
        out_user_r <= 1'b1;
      end else begin
        out_data_r <= {{PAD_W{1'b0}}, cnt_r, word};
        out_last_r <= ~any;
        out_user_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= lpg_pkg::LEN_RESET;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      if (cmd.fill_init) begin
        cnt_r  <= '0;
        done_r <= 1'b0;
      end else if (cmd.emit && !done_r) begin
        if (any) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          done_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.fill_last = (fc_r == LAST_POS);
    sts.out_full  = out_valid_r;
    sts.any       = any;
    sts.done      = done_r;
    sts.sw_more   = (int'(i_r) + 2 < int'(eff_len));
    sts.rw_more   = (int'(lo_r) + 2 < int'(hi_r));
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

>>> rtl/core/lpg_ctrl.sv
// Controller: sequences store fill, result emission, swap and suffix reversal.
module lpg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_restart,
  output logic          in_tready,
  input  logic          cfg_we,
  input  lpg_pkg::sts_t sts,
  output lpg_pkg::cmd_t cmd
);

  localparam logic [3:0] S_FINIT = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_IDLE  = 4'd2;
  localparam logic [3:0] S_EMIT  = 4'd3;
  localparam logic [3:0] S_PIV   = 4'd4;
  localparam logic [3:0] S_FINDJ = 4'd5;
  localparam logic [3:0] S_SW1   = 4'd6;
  localparam logic [3:0] S_SW2   = 4'd7;
  localparam logic [3:0] S_RRD   = 4'd8;
  localparam logic [3:0] S_RW1   = 4'd9;
  localparam logic [3:0] S_RW2   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      S_FINIT: begin
        cmd.fill_init = 1'b1;
        state_nxt     = S_FILL;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) begin
          state_nxt = pend_r ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_restart ? S_FINIT : S_EMIT;
          pend_nxt  = in_restart;
        end
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = (!sts.done && sts.any) ? S_PIV : S_IDLE;
        end
      end
      S_PIV: begin
        cmd.piv   = 1'b1;
        state_nxt = S_FINDJ;
      end
      S_FINDJ: begin
        cmd.findj = 1'b1;
        state_nxt = S_SW1;
      end
      S_SW1: begin
        cmd.sw1   = 1'b1;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        cmd.sw2   = 1'b1;
        state_nxt = sts.sw_more ? S_RRD : S_IDLE;
      end
      S_RRD: begin
        state_nxt = S_RW1;
      end
      S_RW1: begin
        cmd.rw1   = 1'b1;
        state_nxt = S_RW2;
      end
      S_RW2: begin
        cmd.rw2   = 1'b1;
        state_nxt = sts.rw_more ? S_RW1 : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_we) begin
      state_nxt = S_FINIT;
      pend_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FINIT;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

>>> rtl/core/lexicographic_permutation_generator.sv
// Top level of the lexicographic permutation generator.
// Each input item requests one result: the current permutation of 1..L
// (L = length clamped to 1..MAX_LEN), its index and a last flag, after
// which the permutation advances in place. An item with restart set first
// reloads the identity. After the descending permutation has been emitted,
// results carry the exhausted flag until a restart or length write. The
// permutation lives in a small two-read-port RAM driven by a sequencer: an
// item steps through accept and emit, then pivot read, successor search
// and the two swap writes, then one read set-up step and a read/write
// pair per reversed suffix pair when the suffix is longer than one. The
// RAM has no reset; a fill pass runs after reset, after every length
// write and ahead of every restart item, and no item is taken meanwhile.
// The result register lets the next advance run while a result waits.
module lexicographic_permutation_generator #(
  parameter int MAX_LEN = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lpg_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] restart, rest zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lpg_pkg::OUT_TDATA_W-1:0] out_tdata,  // [39:0] perm_word, [61:40] seq_number
  output logic                            out_tlast,  // last_perm
  output logic                            out_tuser,  // exhausted
  input  logic                            cfg_we,
  input  logic [lpg_pkg::LEN_W-1:0]       cfg_wdata   // length
);

  lpg_pkg::cmd_t cmd;
  lpg_pkg::sts_t sts;

  lpg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_tready  (in_tready),
    .cfg_we     (cfg_we),
    .sts        (sts),
    .cmd        (cmd)
  );

  lpg_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
